// File: src/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

  // Level format: unsigned fixed point, full scale is one
  localparam int LEVEL_FRAC_BITS = 15;
  localparam int LEVEL_W         = 16;
  localparam int QUOT_W          = LEVEL_FRAC_BITS + 1;
  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1 << LEVEL_FRAC_BITS);

  // Elapsed time field and the compare width that holds attack plus decay
  localparam int ELAPSED_W = 32;
  localparam int CMP_W     = ELAPSED_W + 1;

  // Register reset values
  localparam int ATTACK_RESET  = 10000;
  localparam int DECAY_RESET   = 50000;
  localparam int RELEASE_RESET = 100000;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RESET = 16'd24576;

  // Job queue between classifier and arithmetic pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_time;
    logic                 gate_pressed;
    logic                 voice_active;
    logic [LEVEL_W-1:0]   onset_level;
  } sample_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               voice_done;
  } env_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Saturate a level to full scale
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

endpackage

// File: src/adsr_front.sv
`timescale 1ns / 1ps

module adsr_front #(
  parameter int TIME_BITS = 24,
  localparam int JOB_W = 2 * adsr_pkg::LEVEL_W + 3 + 2 * TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  adsr_pkg::reg_idx_t     cfg_index,
  input  logic [TIME_BITS-1:0]   cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  adsr_pkg::sample_t      sample,
  input  adsr_pkg::queue_stat_t  qstat,
  output logic                   push,
  output logic [JOB_W-1:0]       job_word
);
  import adsr_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0]   base;
    logic                 use_q;
    logic                 sub;
    logic                 done;
    logic [LEVEL_W-1:0]   mul_a;
    logic [TIME_BITS-1:0] mul_b;
    logic [TIME_BITS-1:0] divisor;
  } job_t;

  logic [TIME_BITS-1:0] attack_time;
  logic [TIME_BITS-1:0] decay_time;
  logic [TIME_BITS-1:0] release_time;
  logic [LEVEL_W-1:0]   sustain_level;

  logic [LEVEL_W-1:0] start_lvl;
  logic [LEVEL_W-1:0] sus_lvl;
  logic [CMP_W-1:0]   t_ext;
  logic [CMP_W-1:0]   a_ext;
  logic [CMP_W-1:0]   r_ext;
  logic [CMP_W-1:0]   ad_ext;
  logic [CMP_W-1:0]   dec_diff;
  logic [CMP_W-1:0]   rel_diff;
  job_t               job;

  // Hold the envelope registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_time   <= TIME_BITS'(ATTACK_RESET);
      decay_time    <= TIME_BITS'(DECAY_RESET);
      sustain_level <= SUSTAIN_RESET;
      release_time  <= TIME_BITS'(RELEASE_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ATTACK:  attack_time   <= cfg_data;
        REG_DECAY:   decay_time    <= cfg_data;
        REG_SUSTAIN: sustain_level <= cfg_data[LEVEL_W-1:0];
        REG_RELEASE: release_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Phase boundaries on a common compare width
  assign start_lvl = clamp_level(sample.onset_level);
  assign sus_lvl   = clamp_level(sustain_level);
  assign t_ext     = CMP_W'(sample.elapsed_time);
  assign a_ext     = CMP_W'(attack_time);
  assign r_ext     = CMP_W'(release_time);
  assign ad_ext    = CMP_W'(attack_time) + CMP_W'(decay_time);
  assign dec_diff  = t_ext - a_ext;
  assign rel_diff  = r_ext - t_ext;

  // Classify the phase and set up multiply, divide and final offset
  always_comb begin
    job      = '0;
    job.done = !sample.gate_pressed && (t_ext > r_ext);
    if (!sample.voice_active) begin
      job.base = '0;
    end else if (sample.gate_pressed) begin
      if (t_ext <= a_ext) begin
        if (attack_time == '0) begin
          job.base = FULL_SCALE;
        end else begin
          job.base    = start_lvl;
          job.use_q   = 1'b1;
          job.mul_a   = FULL_SCALE - start_lvl;
          job.mul_b   = sample.elapsed_time[TIME_BITS-1:0];
          job.divisor = attack_time;
        end
      end else if (t_ext <= ad_ext) begin
        if (decay_time == '0) begin
          job.base = sus_lvl;
        end else begin
          job.base    = FULL_SCALE;
          job.use_q   = 1'b1;
          job.sub     = 1'b1;
          job.mul_a   = FULL_SCALE - sus_lvl;
          job.mul_b   = dec_diff[TIME_BITS-1:0];
          job.divisor = decay_time;
        end
      end else begin
        job.base = sus_lvl;
      end
    end else if (t_ext < r_ext) begin
      job.use_q   = 1'b1;
      job.mul_a   = start_lvl;
      job.mul_b   = rel_diff[TIME_BITS-1:0];
      job.divisor = release_time;
    end
  end

  // Push a word whenever a sample is valid and the queue has room
  assign push         = sample_valid && !qstat.full;
  assign sample_stall = qstat.full;
  assign job_word     = job;

endmodule

// File: src/adsr_queue.sv
`timescale 1ns / 1ps

module adsr_queue #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      din,
  input  logic                  pop,
  output logic [WIDTH-1:0]      dout,
  output adsr_pkg::queue_stat_t stat
);
  import adsr_pkg::*;

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Track fill level
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count_next;
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  assign dout       = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// File: src/adsr_back.sv
`timescale 1ns / 1ps

module adsr_back #(
  parameter int TIME_BITS = 24,
  localparam int JOB_W = 2 * adsr_pkg::LEVEL_W + 3 + 2 * TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [JOB_W-1:0]      job_word,
  input  adsr_pkg::queue_stat_t qstat,
  output logic                  pop,
  output logic                  env_valid,
  input  logic                  env_stall,
  output adsr_pkg::env_t        env
);
  import adsr_pkg::*;

  localparam int PROD_W = LEVEL_W + TIME_BITS;
  localparam int NSTG   = QUOT_W;

  typedef struct packed {
    logic [LEVEL_W-1:0]   base;
    logic                 use_q;
    logic                 sub;
    logic                 done;
    logic [LEVEL_W-1:0]   mul_a;
    logic [TIME_BITS-1:0] mul_b;
    logic [TIME_BITS-1:0] divisor;
  } job_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   base;
    logic                 use_q;
    logic                 sub;
    logic                 done;
    logic [TIME_BITS-1:0] divisor;
  } carry_t;

  job_t                 head;
  logic                 adv;
  logic [PROD_W-1:0]    prod;

  // Stage 0 holds the product, stage i holds i quotient bits
  logic                 stg_valid [NSTG+1];
  carry_t               stg_carry [NSTG+1];
  logic [QUOT_W-1:0]    stg_lq    [NSTG+1];
  logic [TIME_BITS-1:0] stg_rem   [NSTG];

  logic [TIME_BITS:0]   step_trial [NSTG];
  logic [TIME_BITS-1:0] step_rem   [NSTG];
  logic [QUOT_W-1:0]    step_lq    [NSTG];

  carry_t               last;
  logic [LEVEL_W-1:0]   quot;
  logic [LEVEL_W-1:0]   level_next;

  // Advance the whole pipeline when the output register can take a word
  assign adv  = !env_valid || !env_stall;
  assign pop  = adv && !qstat.empty;
  assign head = job_t'(job_word);
  assign prod = PROD_W'(head.mul_a) * PROD_W'(head.mul_b);

  // One restoring divide step per stage
  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      step_trial[i] = {stg_rem[i], stg_lq[i][QUOT_W-1]};
      if (step_trial[i] >= {1'b0, stg_carry[i].divisor}) begin
        step_rem[i] = TIME_BITS'(step_trial[i] - {1'b0, stg_carry[i].divisor});
        step_lq[i]  = {stg_lq[i][QUOT_W-2:0], 1'b1};
      end else begin
        step_rem[i] = step_trial[i][TIME_BITS-1:0];
        step_lq[i]  = {stg_lq[i][QUOT_W-2:0], 1'b0};
      end
    end
  end

  // Apply the quotient to the phase base level
  assign last       = stg_carry[NSTG];
  assign quot       = last.use_q ? stg_lq[NSTG] : '0;
  assign level_next = last.sub ? (last.base - quot) : (last.base + quot);

  // Move valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NSTG; i++) begin
        stg_valid[i] <= 1'b0;
      end
      env_valid <= 1'b0;
    end else if (adv) begin
      stg_valid[0] <= pop;
      for (int i = 0; i < NSTG; i++) begin
        stg_valid[i+1] <= stg_valid[i];
      end
      env_valid <= stg_valid[NSTG];
    end
  end

  // Move payload
  always_ff @(posedge clk) begin
    if (adv) begin
      stg_carry[0] <= '{base: head.base, use_q: head.use_q, sub: head.sub,
                        done: head.done, divisor: head.divisor};
      stg_rem[0]   <= prod[PROD_W-1 -: TIME_BITS];
      stg_lq[0]    <= prod[QUOT_W-1:0];
      for (int i = 0; i < NSTG; i++) begin
        stg_carry[i+1] <= stg_carry[i];
        stg_lq[i+1]    <= step_lq[i];
      end
      for (int i = 0; i < NSTG - 1; i++) begin
        stg_rem[i+1] <= step_rem[i];
      end
      env.level      <= level_next;
      env.voice_done <= last.done;
    end
  end

endmodule

// File: src/adsr_envelope_level_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake                   Word
// sample    sample_valid / sample_stall elapsed_time, gate_pressed, voice_active, onset_level
// env       env_valid / env_stall       level, voice_done
// cfg       cfg_write                   cfg_index, cfg_data (no wait, no read-back)
//
// One sample per cycle sustained while neither stall is raised; a result is registered through
// the job queue, the multiplier register, the 16-stage restoring divider (one quotient bit per
// stage) and the output register.
// rst is synchronous: queue and pipeline empty, registers back to their defaults.
// sample_stall rises only when the four-word job queue is full; env_stall freezes the
// whole arithmetic pipeline while a result is held; the classifier keeps filling the queue.

module adsr_envelope_level_unit #(
  parameter int TIME_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  adsr_pkg::reg_idx_t   cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  adsr_pkg::sample_t    sample,
  output logic                 env_valid,
  input  logic                 env_stall,
  output adsr_pkg::env_t       env
);
  import adsr_pkg::*;

  localparam int JOB_W = 2 * LEVEL_W + 3 + 2 * TIME_BITS;

  queue_stat_t      qstat;
  logic             push;
  logic             pop;
  logic [JOB_W-1:0] job_in;
  logic [JOB_W-1:0] job_out;

  adsr_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .qstat        (qstat),
    .push         (push),
    .job_word     (job_in)
  );

  adsr_queue #(.WIDTH(JOB_W)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_in),
    .pop  (pop),
    .dout (job_out),
    .stat (qstat)
  );

  adsr_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_word  (job_out),
    .qstat     (qstat),
    .pop       (pop),
    .env_valid (env_valid),
    .env_stall (env_stall),
    .env       (env)
  );

  // Level never leaves the unit range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    env_valid |-> (env.level <= FULL_SCALE))
    else $error("envelope level above full scale");

  // A finished voice has decayed to silence
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (env_valid && env.voice_done) |-> (env.level == '0))
    else $error("voice done with nonzero level");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !env_valid)
    else $error("result word present after reset");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import adsr_pkg::*;

  localparam int TIME_BITS   = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Expected envelope words, predicted at sample acceptance
  class envelope_scoreboard;
    logic [TIME_BITS-1:0] attack_us;
    logic [TIME_BITS-1:0] decay_us;
    logic [TIME_BITS-1:0] release_us;
    logic [LEVEL_W-1:0]   sustain_raw;
    env_t                 pending_env[$];
    int unsigned          fail_count;

    function new();
      attack_us   = TIME_BITS'(ATTACK_RESET);
      decay_us    = TIME_BITS'(DECAY_RESET);
      release_us  = TIME_BITS'(RELEASE_RESET);
      sustain_raw = SUSTAIN_RESET;
      fail_count  = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [TIME_BITS-1:0] data);
      case (idx)
        REG_ATTACK:  attack_us   = data;
        REG_DECAY:   decay_us    = data;
        REG_SUSTAIN: sustain_raw = data[LEVEL_W-1:0];
        REG_RELEASE: release_us  = data;
        default: ;
      endcase
    endfunction

    // Piecewise-linear level: attack, decay, sustain while held; linear fall once released
    function env_t predict_env(sample_t s);
      longint unsigned t, fs, start, sus, a, d, r, lvl;
      env_t e;
      t  = s.elapsed_time;
      fs = FULL_SCALE;
      a  = attack_us;
      d  = decay_us;
      r  = release_us;
      start = (s.onset_level > fs) ? fs : s.onset_level;
      sus   = (sustain_raw > fs) ? fs : sustain_raw;
      lvl   = 0;
      if (s.voice_active) begin
        if (s.gate_pressed) begin
          if (t <= a) lvl = (a == 0) ? fs : start + ((fs - start) * t) / a;
          else if (t <= a + d && d != 0) lvl = fs - ((fs - sus) * (t - a)) / d;
          else lvl = sus;
        end else if (t < r) begin
          lvl = (start * (r - t)) / r;
        end
      end
      e.level      = lvl[LEVEL_W-1:0];
      e.voice_done = !s.gate_pressed && (t > r);
      return e;
    endfunction

    function void note_sample(sample_t s);
      pending_env.push_back(predict_env(s));
    endfunction

    function void check_env(env_t got);
      env_t exp;
      if (pending_env.size() == 0) begin
        $display("%0t: unexpected env word: expected none, actual level %0d done %0d",
                 $time, got.level, got.voice_done);
        fail_count++;
      end else begin
        exp = pending_env.pop_front();
        if (got.level !== exp.level) begin
          $display("%0t: level mismatch: expected %0d, actual %0d",
                   $time, exp.level, got.level);
          fail_count++;
        end
        if (got.voice_done !== exp.voice_done) begin
          $display("%0t: voice_done mismatch: expected %0b, actual %0b",
                   $time, exp.voice_done, got.voice_done);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  reg_idx_t             cfg_index;
  logic [TIME_BITS-1:0] cfg_data;
  logic                 sample_valid;
  logic                 sample_stall;
  sample_t              sample_word;
  logic                 env_valid;
  logic                 env_stall;
  env_t                 env_word;

  envelope_scoreboard board;
  bit                 hold_request;
  int unsigned        cycle_count;

  adsr_envelope_level_unit #(.TIME_BITS(TIME_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_word),
    .env_valid    (env_valid),
    .env_stall    (env_stall),
    .env          (env_word)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Note accepted samples, check accepted envelope words
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) board.note_sample(sample_word);
      if (env_valid && !env_stall) board.check_env(env_word);
    end
  end

  // Receiver: stall pattern changes mode now and then; long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    env_stall = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 100;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        env_stall <= 1'b1;
      end else begin
        case (mode)
          0: env_stall <= 1'b0;
          1: env_stall <= ($urandom_range(0, 3) == 0);
          2: env_stall <= ($urandom_range(0, 3) != 0);
          default: env_stall <= ((mode_left % 7) < 3);
        endcase
      end
    end
  end

  function automatic sample_t make_sample(logic [31:0] t, logic gate, logic active,
                                          logic [LEVEL_W-1:0] start);
    sample_t s;
    s.elapsed_time = t;
    s.gate_pressed = gate;
    s.voice_active = active;
    s.onset_level  = start;
    return s;
  endfunction

  // Elapsed time aimed at the phases and edges of the current setting
  function automatic logic [31:0] pick_time();
    longint unsigned a, ad, r, b, v;
    a  = board.attack_us;
    ad = a + board.decay_us;
    r  = board.release_us;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom_range(0, a);
      2, 3: v = a + $urandom_range(0, board.decay_us);
      4: v = $urandom_range(0, r);
      5: begin
        case ($urandom_range(0, 3))
          0: b = 0;
          1: b = a;
          2: b = ad;
          default: b = r;
        endcase
        v = b + $urandom_range(0, 4);
        v = (v < 2) ? 0 : v - 2;
      end
      6: v = $urandom;
      7: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
      8: v = ad + $urandom_range(0, 1000);
      default: v = r + $urandom_range(0, 1000);
    endcase
    return (v > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic sample_t random_sample();
    logic [LEVEL_W-1:0] start;
    case ($urandom_range(0, 7))
      0: start = '0;
      1: start = FULL_SCALE;
      2: start = LEVEL_W'($urandom);
      default: start = LEVEL_W'($urandom_range(0, FULL_SCALE));
    endcase
    return make_sample(pick_time(), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 7) != 0, start);
  endfunction

  function automatic logic [TIME_BITS-1:0] random_time();
    case ($urandom_range(0, 2))
      0: return TIME_BITS'($urandom_range(0, 2000));
      1: return TIME_BITS'($urandom_range(0, 200000));
      default: return TIME_BITS'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until taken
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    sample_word  <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    sample_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (board.pending_env.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input reg_idx_t idx, input logic [TIME_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Drain the pipeline, then load all four registers
  task automatic set_config(input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] d,
                            input logic [TIME_BITS-1:0] s, input logic [TIME_BITS-1:0] r);
    wait_drain();
    program_reg(REG_ATTACK, a);
    program_reg(REG_DECAY, d);
    program_reg(REG_SUSTAIN, s);
    program_reg(REG_RELEASE, r);
  endtask

  // Random words in bursts of random length with random gaps
  task automatic run_random(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      left -= burst;
      repeat (burst) send_sample(random_sample());
      end_burst();
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_ATTACK;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample_word  = '0;
    hold_request = 1'b0;
    cycle_count  = 0;
    board        = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: each phase, its edges, saturated start, inactive voice
    send_sample(make_sample(32'd0, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'd5000, 1'b1, 1'b1, 16'd1000));
    send_sample(make_sample(32'd10000, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'd10001, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'd35000, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'd60000, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'd60001, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF));
    send_sample(make_sample(32'd5000, 1'b1, 1'b1, 16'hFFFF));
    send_sample(make_sample(32'd0, 1'b0, 1'b1, 16'd32768));
    send_sample(make_sample(32'd50000, 1'b0, 1'b1, 16'hFFFF));
    send_sample(make_sample(32'd99999, 1'b0, 1'b1, 16'd32768));
    send_sample(make_sample(32'd100000, 1'b0, 1'b1, 16'd32768));
    send_sample(make_sample(32'd100001, 1'b0, 1'b1, 16'd32768));
    send_sample(make_sample(32'hFFFF_FFFF, 1'b0, 1'b1, 16'd0));
    send_sample(make_sample(32'd5000, 1'b1, 1'b0, 16'd20000));
    send_sample(make_sample(32'd200000, 1'b0, 1'b0, 16'd20000));
    end_burst();

    // Zero times: attack at time zero gives full scale, empty decay, zero release
    set_config('0, '0, 24'h00FFFF, '0);
    send_sample(make_sample(32'd0, 1'b1, 1'b1, 16'd100));
    send_sample(make_sample(32'd1, 1'b1, 1'b1, 16'd100));
    send_sample(make_sample(32'd0, 1'b0, 1'b1, 16'd32768));
    send_sample(make_sample(32'd1, 1'b0, 1'b1, 16'd32768));
    end_burst();

    // Longest times, zero sustain
    set_config(TIME_MAX, TIME_MAX, '0, TIME_MAX);
    send_sample(make_sample({8'd0, TIME_MAX}, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'd33554430, 1'b1, 1'b1, 16'd0));
    send_sample(make_sample(32'd0, 1'b0, 1'b1, 16'd32768));
    send_sample(make_sample({8'd0, TIME_MAX}, 1'b0, 1'b1, 16'd32768));
    end_burst();

    // Random phases over several settings, extremes first
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config('0, '0, '0, '0);
        1: set_config(TIME_MAX, TIME_MAX, 24'd32768, TIME_MAX);
        2: set_config(24'd1, 24'd1, TIME_BITS'($urandom), 24'd1);
        3: set_config(TIME_BITS'(ATTACK_RESET), TIME_BITS'(DECAY_RESET),
                      TIME_BITS'(SUSTAIN_RESET), TIME_BITS'(RELEASE_RESET));
        default: set_config(random_time(), random_time(),
                            TIME_BITS'(($urandom_range(0, 3) == 0)
                                       ? $urandom
                                       : $urandom_range(0, FULL_SCALE)),
                            random_time());
      endcase
      if (p == 4) begin
        // Receiver holds off while the sender keeps offering back to back
        hold_request = 1'b1;
        repeat (60) send_sample(random_sample());
        end_burst();
        run_random(103);
      end else begin
        run_random(163);
      end
    end

    wait_drain();
    repeat (40) @(posedge clk);
    if (board.fail_count == 0 && board.pending_env.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/adsr_pkg.sv
src/adsr_front.sv
src/adsr_queue.sv
src/adsr_back.sv
src/adsr_envelope_level_unit.sv
dv/testbench.sv
